// ----- rtl/bbz_pkg.sv -----
// ----------------------------------------------------------------------------
// bbz_pkg
// Shared constants and control types for the zero-padded box blur.
// ----------------------------------------------------------------------------
package bbz_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 15;

    localparam logic [10:0] RST_WIDTH  = 11'd640;
    localparam logic [15:0] RST_HEIGHT = 16'd480;
    localparam logic [3:0]  RST_RADIUS = 4'd10;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    typedef struct packed {
        logic accept;     // take the input transaction, write the row store
        logic issue;      // issue one window read
        logic div_start;  // load the dividers
        logic div_step;   // one quotient bit
        logic emit;       // load the output register
    } t_cmd;

    typedef struct packed {
        logic produce;    // accepted item completes an output pixel
        logic last_issue; // final read of the window
        logic q_vld;      // read data in flight
        logic div_done;   // last quotient bit this cycle
        logic out_free;   // output register can take a result
    } t_sts;

endpackage

// ----- rtl/bbz_regs.sv -----
// ----------------------------------------------------------------------------
// bbz_regs
// Configuration registers behind the APB port, with range clamping.
// ----------------------------------------------------------------------------
module bbz_regs
    import bbz_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    localparam int COL_W = $clog2(MAX_WIDTH + 16),
    localparam int K_W   = $clog2(2 * MAX_RADIUS + 2)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [COL_W-1:0] o_w_eff,
    output logic [15:0]      o_h_eff,
    output logic [3:0]       o_r_eff,
    output logic [K_W-1:0]   o_k,
    output logic             o_restart
);

    logic [10:0] r_width;
    logic [15:0] r_height;
    logic [3:0]  r_radius;
    logic        wr_en;
    logic [1:0]  idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_radius <= RST_RADIUS;
        end else if (wr_en) begin
            unique case (idx)
                REG_WIDTH:  r_width  <= pwdata[10:0];
                REG_HEIGHT: r_height <= pwdata[15:0];
                REG_RADIUS: r_radius <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // a write to a known register restarts the frame
    assign o_restart = wr_en && (idx == REG_WIDTH || idx == REG_HEIGHT || idx == REG_RADIUS);

    always_comb begin
        unique case (idx)
            REG_WIDTH:  prdata = {21'd0, r_width};
            REG_HEIGHT: prdata = {16'd0, r_height};
            REG_RADIUS: prdata = {28'd0, r_radius};
            default:    prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (r_width == 11'd0) begin
            o_w_eff = COL_W'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            o_w_eff = COL_W'(MAX_WIDTH);
        end else begin
            o_w_eff = COL_W'(r_width);
        end
        o_h_eff = (r_height == 16'd0) ? 16'd1 : r_height;
        o_r_eff = (32'(r_radius) > MAX_RADIUS) ? 4'(MAX_RADIUS) : r_radius;
        o_k     = K_W'(2 * 32'(o_r_eff) + 1);
    end

endmodule

// ----- rtl/bbz_ctrl.sv -----
// ----------------------------------------------------------------------------
// bbz_ctrl
// Sequencer: accept, window read sweep, drain, divide, emit.
// ----------------------------------------------------------------------------
module bbz_ctrl
    import bbz_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SUM   = 5'b00010,
        S_DRAIN = 5'b00100,
        S_DIV   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.produce) n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                // wait for the last read to land in the accumulators
                if (!i_sts.q_vld) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/bbz_dp.sv -----
// ----------------------------------------------------------------------------
// bbz_dp
// Datapath: grid counters, row store, window accumulators, dividers and
// the output register.
// ----------------------------------------------------------------------------
module bbz_dp
    import bbz_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    localparam int COL_W  = $clog2(MAX_WIDTH + 16),
    localparam int K_W    = $clog2(2 * MAX_RADIUS + 2),
    localparam int SLOT_W = $clog2(2 * MAX_RADIUS + 1) > 0 ? $clog2(2 * MAX_RADIUS + 1) : 1,
    localparam int ROW_W  = 17,
    localparam int DEPTH  = (2 * MAX_RADIUS + 1) * MAX_WIDTH,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int AREA_W = 2 * K_W,
    localparam int SUM_W  = AREA_W + 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [COL_W-1:0] i_w_eff,
    input  logic [15:0]      i_h_eff,
    input  logic [3:0]       i_r_eff,
    input  logic [K_W-1:0]   i_k,
    input  logic             i_restart,
    input  logic             i_req_type,
    input  logic [7:0]       i_in_red,
    input  logic [7:0]       i_in_green,
    input  logic [7:0]       i_in_blue,
    input  logic             i_out_ready,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output logic             o_out_valid,
    output logic [7:0]       o_out_red,
    output logic [7:0]       o_out_green,
    output logic [7:0]       o_out_blue,
    output logic             o_frame_last
);

    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [SLOT_W-1:0] r_slot;

    logic [ROW_W-1:0]  h_x, r_x, row_end, y, y0, y1;
    logic [COL_W-1:0]  r_c, col_end, x, x0, x1;
    logic [SLOT_W-1:0] slot_nx, slot0;
    logic              in_img;

    logic [ROW_W-1:0]  r_yy, r_y1;
    logic [COL_W-1:0]  r_xx, r_x0, r_x1;
    logic [SLOT_W-1:0] r_rslot, rslot_nx;
    logic [AREA_W-1:0] r_area;
    logic              r_last;

    logic [23:0]       mem [DEPTH];
    logic [23:0]       r_q;
    logic              r_q_vld;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    logic [SUM_W-1:0]  r_acc [3];
    logic [SUM_W-1:0]  r_rem [3];
    logic [7:0]        r_quo [3];
    logic [SUM_W-1:0]  r_dsr;
    logic [2:0]        r_cnt;
    logic [7:0]        pix [3];

    assign h_x     = ROW_W'(i_h_eff);
    assign r_x     = ROW_W'(i_r_eff);
    assign r_c     = COL_W'(i_r_eff);
    assign row_end = h_x + r_x;
    assign col_end = i_w_eff + r_c;

    assign slot_nx = (32'(r_slot) + 1 == 32'(i_k)) ? '0 : r_slot + 1'b1;
    assign rslot_nx = (32'(r_rslot) + 1 == 32'(i_k)) ? '0 : r_rslot + 1'b1;

    // window bounds of the output pixel finished by this item
    always_comb begin
        in_img = (r_row < h_x) && (r_col < i_w_eff);
        y      = r_row - r_x;
        x      = r_col - r_c;
        y0     = (y >= r_x) ? y - r_x : '0;
        slot0  = (y >= r_x) ? slot_nx : '0;
        y1     = (y + r_x < h_x) ? y + r_x : h_x - 1'b1;
        x0     = (x >= r_c) ? x - r_c : '0;
        x1     = (x + r_c < i_w_eff) ? x + r_c : i_w_eff - 1'b1;
    end

    assign o_sts.produce    = (r_row >= r_x) && (r_col >= r_c);
    assign o_sts.last_issue = (r_yy == r_y1) && (r_xx == r_x1);
    assign o_sts.q_vld      = r_q_vld;
    assign o_sts.div_done   = (r_cnt == 3'd7);
    assign o_sts.out_free   = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (i_restart) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (i_cmd.accept) begin
            if (r_col + 1'b1 >= col_end) begin
                r_col <= '0;
                if (r_row + 1'b1 >= row_end) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= r_row + 1'b1;
                    r_slot <= slot_nx;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // window sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_yy    <= y0;
            r_y1    <= y1;
            r_xx    <= x0;
            r_x0    <= x0;
            r_x1    <= x1;
            r_rslot <= slot0;
            r_area  <= AREA_W'(i_k) * AREA_W'(i_k);
            r_last  <= (y == h_x - 1'b1) && (x == i_w_eff - 1'b1);
        end else if (i_cmd.issue) begin
            if (r_xx == r_x1) begin
                r_xx    <= r_x0;
                r_yy    <= r_yy + 1'b1;
                r_rslot <= rslot_nx;
            end else begin
                r_xx <= r_xx + 1'b1;
            end
        end
    end

    assign wr_addr = ADDR_W'(r_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_col);
    assign rd_addr = ADDR_W'(r_rslot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_xx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && in_img) begin
            mem[wr_addr] <= i_req_type ? 24'd0 : {i_in_red, i_in_green, i_in_blue};
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else begin
            r_q_vld <= i_cmd.issue;
        end
    end

    assign pix[0] = r_q[23:16];
    assign pix[1] = r_q[15:8];
    assign pix[2] = r_q[7:0];

    // accumulate, then restoring division, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dsr <= {r_area, 8'd0} >> 1;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dsr <= r_dsr >> 1;
            r_cnt <= r_cnt + 1'b1;
        end
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.accept) begin
                r_acc[c] <= '0;
            end else if (r_q_vld) begin
                r_acc[c] <= r_acc[c] + SUM_W'(pix[c]);
            end
            if (i_cmd.div_start) begin
                r_rem[c] <= r_acc[c];
                r_quo[c] <= '0;
            end else if (i_cmd.div_step) begin
                if (r_rem[c] >= r_dsr) begin
                    r_rem[c] <= r_rem[c] - r_dsr;
                    r_quo[c] <= {r_quo[c][6:0], 1'b1};
                end else begin
                    r_quo[c] <= {r_quo[c][6:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out_red    <= r_quo[0];
            o_out_green  <= r_quo[1];
            o_out_blue   <= r_quo[2];
            o_frame_last <= r_last;
        end
    end

endmodule

// ----- rtl/box_blur_zero_padded.sv -----
// ----------------------------------------------------------------------------
// box_blur_zero_padded
// Square box blur of side 2*radius+1 on RGB pixels, zeros outside the image.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_req_type, i_in_red/green/blue
// output    out        o_valid / i_ready    o_out_red/green/blue, o_frame_last
// config    in         APB psel/penable     paddr, pwdata, prdata
//
// An item that finishes no output pixel is only accepted. One that does is
// accepted, then its n window pixels inside the image (at most k*k) are
// read from the single read port of the row store one pixel a cycle, the
// last read drains, and a restoring divide by k*k gives the output pixel.
// A waiting result holds in the output register; the next item is taken
// meanwhile, and only the emit of the following result stalls on it.
// Reset is synchronous, active low; the row store is not cleared.
// ----------------------------------------------------------------------------
module box_blur_zero_padded
    import bbz_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_blue,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic        o_frame_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int COL_W = $clog2(MAX_WIDTH + 16);
    localparam int K_W   = $clog2(2 * MAX_RADIUS + 2);

    logic [COL_W-1:0] w_eff;
    logic [15:0]      h_eff;
    logic [3:0]       r_eff;
    logic [K_W-1:0]   k;
    logic             restart;
    t_cmd             cmd;
    t_sts             sts;

    bbz_regs #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_regs (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .o_w_eff(w_eff), .o_h_eff(h_eff), .o_r_eff(r_eff), .o_k(k),
        .o_restart(restart)
    );

    bbz_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    bbz_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_w_eff(w_eff), .i_h_eff(h_eff), .i_r_eff(r_eff), .i_k(k),
        .i_restart(restart),
        .i_req_type(i_req_type), .i_in_red(i_in_red),
        .i_in_green(i_in_green), .i_in_blue(i_in_blue),
        .i_out_ready(i_ready), .i_cmd(cmd), .o_sts(sts),
        .o_out_valid(o_valid), .o_out_red(o_out_red),
        .o_out_green(o_out_green), .o_out_blue(o_out_blue),
        .o_frame_last(o_frame_last)
    );

    a_issue_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |=> sts.q_vld)
        else $error("window read did not return data");

    a_div_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !sts.q_vld)
        else $error("divide started with a read in flight");

    a_accept_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |-> !cmd.issue && !cmd.emit && !cmd.div_step)
        else $error("accept overlaps window work");

endmodule
